// ===== rtl/core/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Complete binary tree check - shared definitions
// Field widths, the absent-child code, sequencer states and the result beat.
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int CHILD_W       = 7;
    localparam int COUNT_W       = 7;
    localparam int ID_W          = 6;

    localparam logic [CHILD_W-1:0] NO_CHILD = {CHILD_W{1'b1}};

    typedef enum logic [3:0] {
        S_LOAD,
        S_MK_RD,
        S_MK_L,
        S_MK_R,
        S_RS_RD,
        S_RS_CHK,
        S_WK_POP,
        S_WK_FETCH,
        S_WK_EVAL,
        S_WK_PUSHR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic            is_complete;
        logic [ID_W-1:0] node_id;
        logic            malformed;
    } result_t;

endpackage

// ===== rtl/core/cbt_seq.sv =====
// ----------------------------------------------------------------------------
// Complete binary tree check - sequencer
// Loads the child table, marks children, searches the root and walks the
// tree in level order through a queue held in the work memory.
// ----------------------------------------------------------------------------
module cbt_seq #(
    parameter int MAX_NODES = cbt_pkg::MAX_NODES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [cbt_pkg::CHILD_W-1:0]   left_child,
    input  logic signed [cbt_pkg::CHILD_W-1:0]   right_child,
    input  logic [$clog2(MAX_NODES+1)-1:0]       cnt,
    input  logic                                 out_free,
    output logic                                 res_valid,
    output cbt_pkg::result_t                     res
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int IW = $clog2(MAX_NODES);
    localparam int TW = 2 * cbt_pkg::CHILD_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_NODES - 1);
    localparam logic [CW-1:0] FULL_OCC  = CW'(MAX_NODES);

    // child table: {left, right}; work memory: parent mark, later the queue
    logic [TW-1:0] child_mem [MAX_NODES];
    logic [IW-1:0] work_mem  [MAX_NODES];

    logic                        child_we;
    logic [IW-1:0]               child_waddr;
    logic                        child_re;
    logic [IW-1:0]               child_raddr;
    logic [TW-1:0]               child_q_reg;
    logic                        work_we;
    logic [IW-1:0]               work_waddr;
    logic [IW-1:0]               work_wdata;
    logic                        work_re;
    logic [IW-1:0]               work_raddr;
    logic [IW-1:0]               work_q_reg;

    cbt_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] load_reg, load_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          bad_reg, bad_next;
    logic [IW-1:0] root_reg, root_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] deq_reg, deq_next;
    logic          leaf_reg, leaf_next;
    logic [IW-1:0] now_reg, now_next;
    logic          complete_reg, complete_next;
    logic [IW-1:0] node_reg, node_next;

    logic [cbt_pkg::CHILD_W-1:0] child_l;
    logic [cbt_pkg::CHILD_W-1:0] child_r;
    logic          l_present, r_present;
    logic          l_in, r_in;
    logic [CW-1:0] load_inc, idx_inc;
    logic          load_last, idx_last;
    logic          walk_fail;
    logic          walk_state;

    assign child_l   = child_q_reg[TW-1:cbt_pkg::CHILD_W];
    assign child_r   = child_q_reg[cbt_pkg::CHILD_W-1:0];
    assign l_present = (child_l != cbt_pkg::NO_CHILD);
    assign r_present = (child_r != cbt_pkg::NO_CHILD);
    assign l_in      = (32'(child_l) < 32'(cnt));
    assign r_in      = (32'(child_r) < 32'(cnt));
    assign load_inc  = load_reg + 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign load_last = (load_inc >= cnt);
    assign idx_last  = (idx_inc >= cnt);
    assign walk_fail = (leaf_reg && (l_present || r_present)) || (!l_present && r_present);
    assign walk_state = (state_reg == cbt_pkg::S_WK_POP) || (state_reg == cbt_pkg::S_WK_FETCH)
                     || (state_reg == cbt_pkg::S_WK_EVAL) || (state_reg == cbt_pkg::S_WK_PUSHR);

    assign child_waddr = load_reg[IW-1:0];

    // memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= {left_child, right_child};
        end
        if (child_re)
        begin
            child_q_reg <= child_mem[child_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (work_re)
        begin
            work_q_reg <= work_mem[work_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbt_pkg::S_LOAD:
            begin
                if (in_valid && load_last)
                begin
                    state_next = cbt_pkg::S_MK_RD;
                end
            end
            cbt_pkg::S_MK_RD:  state_next = cbt_pkg::S_MK_L;
            cbt_pkg::S_MK_L:   state_next = cbt_pkg::S_MK_R;
            cbt_pkg::S_MK_R:
            begin
                if (!idx_last)
                begin
                    state_next = cbt_pkg::S_MK_L;
                end
                else if (bad_reg || (r_present && !r_in))
                begin
                    state_next = cbt_pkg::S_DONE;
                end
                else
                begin
                    state_next = cbt_pkg::S_RS_RD;
                end
            end
            cbt_pkg::S_RS_RD:  state_next = cbt_pkg::S_RS_CHK;
            cbt_pkg::S_RS_CHK:
            begin
                if (work_q_reg == '0)
                begin
                    state_next = cbt_pkg::S_WK_POP;
                end
                else if (idx_last)
                begin
                    state_next = cbt_pkg::S_DONE;
                end
                else
                begin
                    state_next = cbt_pkg::S_RS_RD;
                end
            end
            cbt_pkg::S_WK_POP:
            begin
                state_next = (occ_reg == '0) ? cbt_pkg::S_DONE : cbt_pkg::S_WK_FETCH;
            end
            cbt_pkg::S_WK_FETCH: state_next = cbt_pkg::S_WK_EVAL;
            cbt_pkg::S_WK_EVAL:
            begin
                if (walk_fail || (deq_reg == cnt))
                begin
                    state_next = cbt_pkg::S_DONE;
                end
                else if (r_present)
                begin
                    state_next = cbt_pkg::S_WK_PUSHR;
                end
                else
                begin
                    state_next = cbt_pkg::S_WK_POP;
                end
            end
            cbt_pkg::S_WK_PUSHR: state_next = cbt_pkg::S_WK_POP;
            cbt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = cbt_pkg::S_LOAD;
                end
            end
            default: state_next = cbt_pkg::S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        child_we      = 1'b0;
        child_re      = 1'b0;
        child_raddr   = '0;
        work_we       = 1'b0;
        work_waddr    = '0;
        work_wdata    = '0;
        work_re       = 1'b0;
        work_raddr    = '0;
        load_next     = load_reg;
        idx_next      = idx_reg;
        bad_next      = bad_reg;
        root_next     = root_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        deq_next      = deq_reg;
        leaf_next     = leaf_reg;
        now_next      = now_reg;
        complete_next = complete_reg;
        node_next     = node_reg;
        unique case (state_reg)
            cbt_pkg::S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // store the node and drop its parent mark from the last tree
                    child_we   = 1'b1;
                    work_we    = 1'b1;
                    work_waddr = load_reg[IW-1:0];
                    if (load_last)
                    begin
                        load_next = '0;
                        idx_next  = '0;
                        bad_next  = 1'b0;
                    end
                    else
                    begin
                        load_next = load_inc;
                    end
                end
            end
            cbt_pkg::S_MK_RD:
            begin
                child_re    = 1'b1;
                child_raddr = idx_reg[IW-1:0];
            end
            cbt_pkg::S_MK_L:
            begin
                if (l_present)
                begin
                    if (l_in)
                    begin
                        work_we    = 1'b1;
                        work_waddr = IW'(child_l);
                        work_wdata = IW'(1);
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
            end
            cbt_pkg::S_MK_R:
            begin
                if (r_present)
                begin
                    if (r_in)
                    begin
                        work_we    = 1'b1;
                        work_waddr = IW'(child_r);
                        work_wdata = IW'(1);
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                if (idx_last)
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next    = idx_inc;
                    child_re    = 1'b1;
                    child_raddr = idx_inc[IW-1:0];
                end
            end
            cbt_pkg::S_RS_RD:
            begin
                work_re    = 1'b1;
                work_raddr = idx_reg[IW-1:0];
            end
            cbt_pkg::S_RS_CHK:
            begin
                if (work_q_reg == '0)
                begin
                    // root found: seed the queue with it
                    root_next     = idx_reg[IW-1:0];
                    work_we       = 1'b1;
                    work_waddr    = '0;
                    work_wdata    = idx_reg[IW-1:0];
                    head_next     = '0;
                    tail_next     = IW'(1);
                    occ_next      = CW'(1);
                    deq_next      = '0;
                    leaf_next     = 1'b0;
                    complete_next = 1'b0;
                end
                else if (idx_last)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            cbt_pkg::S_WK_POP:
            begin
                if (occ_reg != '0)
                begin
                    work_re    = 1'b1;
                    work_raddr = head_reg;
                    head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    occ_next   = occ_reg - 1'b1;
                    deq_next   = deq_reg + 1'b1;
                end
            end
            cbt_pkg::S_WK_FETCH:
            begin
                now_next    = work_q_reg;
                child_re    = 1'b1;
                child_raddr = work_q_reg;
            end
            cbt_pkg::S_WK_EVAL:
            begin
                if (!r_present)
                begin
                    leaf_next = 1'b1;
                end
                if (!walk_fail)
                begin
                    if (deq_reg == cnt)
                    begin
                        complete_next = 1'b1;
                        node_next     = now_reg;
                    end
                    else if (l_present && (occ_reg < FULL_OCC))
                    begin
                        work_we    = 1'b1;
                        work_waddr = tail_reg;
                        work_wdata = IW'(child_l);
                        tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                        occ_next   = occ_reg + 1'b1;
                    end
                end
            end
            cbt_pkg::S_WK_PUSHR:
            begin
                if (occ_reg < FULL_OCC)
                begin
                    work_we    = 1'b1;
                    work_waddr = tail_reg;
                    work_wdata = IW'(child_r);
                    tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                    occ_next   = occ_reg + 1'b1;
                end
            end
            cbt_pkg::S_DONE:
            begin
                res_valid = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res.malformed   = bad_reg;
    assign res.is_complete = complete_reg && !bad_reg;
    assign res.node_id     = bad_reg      ? '0 :
                             complete_reg ? cbt_pkg::ID_W'(node_reg) :
                                            cbt_pkg::ID_W'(root_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cbt_pkg::S_LOAD;
            load_reg     <= '0;
            idx_reg      <= '0;
            bad_reg      <= 1'b0;
            root_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            deq_reg      <= '0;
            leaf_reg     <= 1'b0;
            complete_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_reg     <= load_next;
            idx_reg      <= idx_next;
            bad_reg      <= bad_next;
            root_reg     <= root_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            deq_reg      <= deq_next;
            leaf_reg     <= leaf_next;
            complete_reg <= complete_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        node_reg <= node_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_OCC)
        else $error("queue occupancy above depth");

    a_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_state && occ_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_deq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_state |-> (deq_reg <= cnt))
        else $error("walk visited more nodes than the tree holds");

    a_complete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbt_pkg::S_DONE && complete_reg && !bad_reg) |-> (deq_reg == cnt))
        else $error("complete result without a full walk");

    a_result_reload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == cbt_pkg::S_LOAD && load_reg == '0))
        else $error("sequencer did not return to loading after a result");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt != '0) && (cnt <= FULL_OCC))
        else $error("node count outside 1..MAX_NODES");

endmodule

// ===== rtl/core/complete_binary_tree_check_unit.sv =====
// Input: one beat per cycle while a tree loads and in_valid is high; after the
// last node of a tree the sequencer marks children, searches the root and
// walks the tree in level order, all bound by the single read port of each
// memory, then holds the result beat until the output register is free.
// Throughput: one tree at a time; the next tree loads after the result beat.
// Reset: node_count returns to 1, loading restarts at node 0, no result pending.
// ----------------------------------------------------------------------------
// Complete binary tree check - top level
// Holds the node count register and the result output register around the
// tree sequencer.
// ----------------------------------------------------------------------------
module complete_binary_tree_check_unit #(
    parameter int MAX_NODES = cbt_pkg::MAX_NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbt_pkg::COUNT_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [cbt_pkg::CHILD_W-1:0]  left_child,
    input  logic signed [cbt_pkg::CHILD_W-1:0]  right_child,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                is_complete,
    output logic [cbt_pkg::ID_W-1:0]            node_id,
    output logic                                malformed
);

    localparam int CW = $clog2(MAX_NODES + 1);

    logic [cbt_pkg::COUNT_W-1:0] node_count_reg, node_count_next;
    logic [CW-1:0]               cnt;
    logic                        out_valid_reg, out_valid_next;
    cbt_pkg::result_t            res_reg, res_next;
    cbt_pkg::result_t            seq_res;
    logic                        seq_res_valid;
    logic                        out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_valid)
        begin
            node_count_next = cfg_data;
        end
    end

    // clamp the count to 1..MAX_NODES
    always_comb
    begin
        priority if (node_count_reg == '0)
        begin
            cnt = CW'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            cnt = CW'(MAX_NODES);
        end
        else
        begin
            cnt = CW'(node_count_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (seq_res_valid)
        begin
            out_valid_next = 1'b1;
            res_next       = seq_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= cbt_pkg::COUNT_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    cbt_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .left_child  (left_child),
        .right_child (right_child),
        .cnt         (cnt),
        .out_free    (out_free),
        .res_valid   (seq_res_valid),
        .res         (seq_res)
    );

    assign out_valid   = out_valid_reg;
    assign is_complete = res_reg.is_complete;
    assign node_id     = res_reg.node_id;
    assign malformed   = res_reg.malformed;

endmodule
